// File: design/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and helpers for the life generation step
// Register widths, configuration register codes, rule codes and the
// neighbor count / next state logic for one 3x3 window.
// ----------------------------------------------------------------------------
package lgs_pkg;

	// default line store depth and row limit
	localparam int DefMaxCols = 64;
	localparam int MaxRows    = 1024;

	// field and register widths
	localparam int RowsW    = 11;
	localparam int ColsRegW = 7;
	localparam int OutRowW  = 10;
	localparam int OutColW  = 6;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 11;
	localparam int LineW    = 2;
	localparam int WinW     = 9;
	localparam int NbW      = 4;

	// configuration register index
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_RULE = 2'd2
	} cfg_idx_t;

	// rule select
	typedef enum logic {
		RULE_CLASSIC = 1'b0,
		RULE_B       = 1'b1
	} rule_t;

	// count live neighbors, centre (bit 4) excluded
	function automatic logic [NbW-1:0] count_neighbors(logic [WinW-1:0] w);
		logic [NbW-1:0] n;
		n = '0;
		for (int k = 0; k < WinW; k++) begin
			if (k != 4) begin
				n = n + NbW'(w[k]);
			end
		end
		return n;
	endfunction

	// next state of the centre cell
	function automatic logic next_state(logic centre, logic [NbW-1:0] nb, rule_t rule);
		logic nxt;
		nxt = centre;
		unique case (rule)
			RULE_B: begin
				if (nb == NbW'(2)) nxt = 1'b1;
			end
			RULE_CLASSIC: begin
				if (centre && (nb < NbW'(2) || nb > NbW'(3))) nxt = 1'b0;
				else if (!centre && nb == NbW'(3)) nxt = 1'b1;
			end
			default: nxt = centre;
		endcase
		return nxt;
	endfunction

endpackage

// File: design/lgs_line_store.sv
// ----------------------------------------------------------------------------
// lgs_line_store: two-row line store
// One entry per column holding the two rows above the arriving one.
// Registered read with write-through when a write hits the read address.
// ----------------------------------------------------------------------------
module lgs_line_store #(
	parameter int DEPTH = lgs_pkg::DefMaxCols
) (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic [lgs_pkg::LineW-1:0]           rd_data,
	input  logic                                wr_en,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic [lgs_pkg::LineW-1:0]           wr_data
);
	import lgs_pkg::*;

	logic [LineW-1:0] mem [DEPTH];
	logic [LineW-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, forwards a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) rd_data_q <= wr_data;
			else rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/life_generation_step.sv
// ----------------------------------------------------------------------------
// life_generation_step: one generation of a life-like automaton on a raster
// Result path: stage 1 registers the item and its line store read, and the
//   result register loads when stage 1 moves on.
// Throughput: one item per cycle (one line store port pair) unless output stalls.
// Reset: counters, window, valids and config return to defaults; the line
//   store is not cleared (stale entries are masked by the row position).
// ----------------------------------------------------------------------------
module life_generation_step #(
	parameter int MAX_COLS = lgs_pkg::DefMaxCols
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [lgs_pkg::CfgDataW-1:0]   cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cell_alive,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           next_alive,
	output logic                           cell_changed,
	output logic [lgs_pkg::OutRowW-1:0]    out_row,
	output logic [lgs_pkg::OutColW-1:0]    out_col,
	output logic                           frame_last
);
	import lgs_pkg::*;

	localparam int ColW    = $clog2(MAX_COLS);
	localparam int ColCntW = $clog2(MAX_COLS + 1);

	// configuration registers
	logic [RowsW-1:0]    grid_rows_q;
	logic [ColsRegW-1:0] grid_cols_q;
	rule_t               rule_q;
	logic                size_wr;

	assign size_wr = cfg_we &&
		(cfg_idx_t'(cfg_index) == CFG_ROWS || cfg_idx_t'(cfg_index) == CFG_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= RowsW'(1);
			grid_cols_q <= ColsRegW'(1);
			rule_q      <= RULE_CLASSIC;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROWS: grid_rows_q <= cfg_data[RowsW-1:0];
				CFG_COLS: grid_cols_q <= cfg_data[ColsRegW-1:0];
				CFG_RULE: rule_q      <= rule_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	// effective grid size, zero taken as one, saturated at the maximum
	logic [RowsW-1:0]   rows_eff;
	logic [ColCntW-1:0] cols_eff;
	logic [RowsW-1:0]   rows_p1;

	always_comb begin
		if (grid_rows_q == '0) rows_eff = RowsW'(1);
		else if (grid_rows_q > RowsW'(MaxRows)) rows_eff = RowsW'(MaxRows);
		else rows_eff = grid_rows_q;

		if (grid_cols_q == '0) cols_eff = ColCntW'(1);
		else if (32'(grid_cols_q) > 32'(MAX_COLS)) cols_eff = ColCntW'(MAX_COLS);
		else cols_eff = ColCntW'(grid_cols_q);
	end

	assign rows_p1 = rows_eff + RowsW'(1);

	// handshake
	logic v_s1_q;
	logic s1_go;
	logic accept_in;
	logic out_valid_q;

	assign s1_go     = v_s1_q && (!out_valid_q || out_ready);
	assign in_ready  = !v_s1_q || s1_go;
	assign accept_in = in_valid && in_ready;

	// raster position of the next request, fillers included
	logic [RowsW-1:0] r_q;
	logic [ColW-1:0]  c_q;
	logic             col_wrap;
	logic             frame_end;

	assign col_wrap  = (ColCntW'(c_q) + ColCntW'(1)) >= cols_eff;
	assign frame_end = (c_q == '0) && (r_q >= rows_p1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (size_wr) begin
			r_q <= '0;
			c_q <= '0;
		end else if (accept_in) begin
			priority if (frame_end) begin
				r_q <= '0;
				c_q <= '0;
			end else if (col_wrap) begin
				r_q <= r_q + RowsW'(1);
				c_q <= '0;
			end else begin
				c_q <= c_q + ColW'(1);
			end
		end
	end

	// stage 1 register
	logic [RowsW-1:0] r_s1;
	logic [ColW-1:0]  c_s1;
	logic             cur_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept_in) begin
			v_s1_q <= 1'b1;
		end else if (s1_go) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			r_s1   <= r_q;
			c_s1   <= c_q;
			cur_s1 <= (r_q < rows_eff) && cell_alive;
		end
	end

	// line store: read at accept, write back when stage 1 moves on
	logic [LineW-1:0] st_s1;

	lgs_line_store #(
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept_in),
		.rd_addr (c_q),
		.rd_data (st_s1),
		.wr_en   (s1_go),
		.wr_addr (c_s1),
		.wr_data ({st_s1[0], cur_s1})
	);

	// window update and cell evaluation
	logic [WinW-1:0]  win_q;
	logic [WinW-1:0]  eval_win;
	logic [WinW-1:0]  win_next;
	logic [2:0]       newcol;
	logic             top_ok;
	logic             mid_ok;
	logic             col0;
	logic             emit;
	logic             nxt;
	logic [NbW-1:0]   nb;
	logic [RowsW-1:0] row_m1;
	logic [RowsW-1:0] row_m2;
	logic [OutRowW-1:0] row_o;
	logic [OutColW-1:0] col_o;
	logic             last_o;

	always_comb begin
		top_ok   = (r_s1 >= RowsW'(2)) && (r_s1 <= rows_p1);
		mid_ok   = (r_s1 >= RowsW'(1)) && (r_s1 <= rows_eff);
		newcol   = {cur_s1, st_s1[0] & mid_ok, st_s1[1] & top_ok};
		col0     = (c_s1 == '0);
		// at column zero the right edge of the previous row is dead
		eval_win = {(col0 ? 3'b000 : newcol), win_q[WinW-1:3]};
		win_next = col0 ? {newcol, 6'b000000} : eval_win;
		emit     = col0 ? top_ok : mid_ok;
		nb       = count_neighbors(eval_win);
		nxt      = next_state(eval_win[4], nb, rule_q);
		row_m1   = r_s1 - RowsW'(1);
		row_m2   = r_s1 - RowsW'(2);
		row_o    = col0 ? row_m2[OutRowW-1:0] : row_m1[OutRowW-1:0];
		col_o    = col0 ? OutColW'(cols_eff - ColCntW'(1)) : OutColW'(c_s1 - ColW'(1));
		last_o   = col0 && (r_s1 == rows_p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go) begin
			win_q <= win_next;
		end
	end

	// result register
	logic               next_alive_q;
	logic               cell_changed_q;
	logic [OutRowW-1:0] out_row_q;
	logic [OutColW-1:0] out_col_q;
	logic               frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			next_alive_q   <= nxt;
			cell_changed_q <= nxt ^ eval_win[4];
			out_row_q      <= row_o;
			out_col_q      <= col_o;
			frame_last_q   <= last_o;
		end
	end

	assign out_valid    = out_valid_q;
	assign next_alive   = next_alive_q;
	assign cell_changed = cell_changed_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign frame_last   = frame_last_q;

	// checks
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ColCntW'(c_q) < cols_eff)
		else $error("column counter beyond grid width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_q <= rows_p1)
		else $error("row counter beyond last filler row");

	a_last_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_last_q |-> out_col_q == OutColW'(cols_eff - ColCntW'(1)))
		else $error("frame end flagged away from the last column");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_row_q) && $stable(out_col_q))
		else $error("pending result dropped or overwritten");

endmodule
